### src/fts_pkg.sv
// Package for the fixed timestep scheduler: field widths, register codes, mode codes
// and reset values. No dependencies; every other file refers to it by scoped names.
package fts_pkg;

  // Defaults for the top level parameters.
  localparam int unsigned SubstepLimitDef = 32;
  localparam int unsigned TimeWidthDef    = 32;

  // Widths of the port fields.
  localparam int unsigned DeltaW    = 24;
  localparam int unsigned FixedW    = 20;
  localparam int unsigned SubstepsW = 6;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned OutW      = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 20;

  // Entries of the queue between the front and back parts.
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEPPING_MODE = 2'd0,
    CFG_FIXED_STEP    = 2'd1,
    CFG_MAX_SUBSTEPS  = 2'd2
  } cfg_idx_e;

  typedef enum logic [ModeW-1:0] {
    MODE_VARIABLE   = 2'd0,
    MODE_FIXED      = 2'd1,
    MODE_SEMI_FIXED = 2'd2
  } mode_e;

  localparam logic [ModeW-1:0]     ModeReset        = MODE_FIXED;
  localparam logic [FixedW-1:0]    FixedStepReset   = 20'd16667;
  localparam logic [SubstepsW-1:0] MaxSubstepsReset = 6'd4;

endpackage

### src/fixed_timestep_scheduler.sv
// Top level of the fixed timestep scheduler: front, queue, divider and back part.
// Depends on fts_pkg, fts_front, fts_queue, fts_divider and fts_back.
//
//   channel   direction  handshake                     payload
//   config    in         cfg_we_i (no wait)            cfg_idx_i, cfg_wdata_i
//   frame     in         frame_valid_i/frame_ready_o   frame_delta_i
//   step      out        step_valid_o/step_ready_i     step_ticks_o, has_step_o,
//                                                      is_last_o, leftover_ticks_o
//
// Sequence: a frame is popped, added to the accumulator and classified; each step then
// takes a check and a take, a last check ends the run and a flush sends the last result.
// Semi-fixed mode waits for the one-bit-a-cycle divider when the step widens.
// Reset clears the accumulator to zero and loads the register reset values.
// Stalls: the queue holds two frames while the back part works; a stalled step
// output holds the sequencer, and the front keeps taking frames until the queue fills.
module fixed_timestep_scheduler #(
  parameter int unsigned SubstepLimit = fts_pkg::SubstepLimitDef,
  parameter int unsigned TimeWidth    = fts_pkg::TimeWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fts_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         frame_valid_i,
  output logic                         frame_ready_o,
  input  logic [fts_pkg::DeltaW-1:0]   frame_delta_i,
  output logic                         step_valid_o,
  input  logic                         step_ready_i,
  output logic [fts_pkg::OutW-1:0]     step_ticks_o,
  output logic                         has_step_o,
  output logic                         is_last_o,
  output logic [fts_pkg::OutW-1:0]     leftover_ticks_o
);

  // Substep count field and the product fixed_step * limit it scales.
  localparam int unsigned LimW   = $clog2(SubstepLimit + 1);
  localparam int unsigned ProdW  = fts_pkg::FixedW + LimW;
  localparam int unsigned EntryW = fts_pkg::DeltaW + fts_pkg::ModeW + fts_pkg::FixedW
                                   + LimW + ProdW;

  logic                 push_valid;
  logic                 push_ready;
  logic [EntryW-1:0]    push_data;
  logic                 pop_valid;
  logic                 pop_ready;
  logic [EntryW-1:0]    pop_data;
  logic                 div_start;
  logic [TimeWidth-1:0] div_dividend;
  logic [LimW-1:0]      div_divisor;
  logic                 div_done;
  logic [TimeWidth-1:0] div_quotient;

  // Register settings and classify each frame at its transfer.
  fts_front #(
    .SubstepLimit (SubstepLimit),
    .LimW         (LimW),
    .ProdW        (ProdW),
    .EntryW       (EntryW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .frame_valid_i (frame_valid_i),
    .frame_ready_o (frame_ready_o),
    .frame_delta_i (frame_delta_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  // Decouple frame intake from step emission.
  fts_queue #(
    .Width (EntryW),
    .Depth (fts_pkg::QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Widened semi-fixed step: accumulator / limit.
  fts_divider #(
    .TimeWidth    (TimeWidth),
    .SubstepLimit (SubstepLimit),
    .LimW         (LimW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // Advance the accumulator and emit the run of steps for one frame.
  fts_back #(
    .TimeWidth    (TimeWidth),
    .SubstepLimit (SubstepLimit),
    .LimW         (LimW),
    .ProdW        (ProdW),
    .EntryW       (EntryW)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_data_i       (pop_data),
    .div_start_o      (div_start),
    .div_dividend_o   (div_dividend),
    .div_divisor_o    (div_divisor),
    .div_done_i       (div_done),
    .div_quotient_i   (div_quotient),
    .step_valid_o     (step_valid_o),
    .step_ready_i     (step_ready_i),
    .step_ticks_o     (step_ticks_o),
    .has_step_o       (has_step_o),
    .is_last_o        (is_last_o),
    .leftover_ticks_o (leftover_ticks_o)
  );

endmodule

### src/fts_front.sv
// Front part of the fixed timestep scheduler: configuration registers and frame intake.
// Classifies each frame with the current settings and hands it to the queue. Uses fts_pkg.
module fts_front #(
  parameter int unsigned SubstepLimit = fts_pkg::SubstepLimitDef,
  parameter int unsigned LimW         = $clog2(SubstepLimit + 1),
  parameter int unsigned ProdW        = fts_pkg::FixedW + LimW,
  parameter int unsigned EntryW       = fts_pkg::DeltaW + fts_pkg::ModeW + fts_pkg::FixedW
                                        + LimW + ProdW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fts_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         frame_valid_i,
  output logic                         frame_ready_o,
  input  logic [fts_pkg::DeltaW-1:0]   frame_delta_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output logic [EntryW-1:0]            push_data_o
);

  localparam int unsigned ClW = (LimW > fts_pkg::SubstepsW) ? LimW : fts_pkg::SubstepsW;

  logic [fts_pkg::ModeW-1:0]     mode_q;
  logic [fts_pkg::FixedW-1:0]    fixed_q;
  logic [fts_pkg::SubstepsW-1:0] substeps_q;

  logic [fts_pkg::FixedW-1:0] fixed_eff;
  logic [ClW-1:0]             substeps_ext;
  logic [ClW-1:0]             limit_max;
  logic [ClW-1:0]             limit_clamped;
  logic [LimW-1:0]            limit;
  logic [ProdW-1:0]           prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= fts_pkg::ModeReset;
      fixed_q    <= fts_pkg::FixedStepReset;
      substeps_q <= fts_pkg::MaxSubstepsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fts_pkg::CFG_STEPPING_MODE: mode_q     <= cfg_wdata_i[fts_pkg::ModeW-1:0];
        fts_pkg::CFG_FIXED_STEP:    fixed_q    <= cfg_wdata_i[fts_pkg::FixedW-1:0];
        fts_pkg::CFG_MAX_SUBSTEPS:  substeps_q <= cfg_wdata_i[fts_pkg::SubstepsW-1:0];
        default: ;
      endcase
    end
  end

  // Treat a zero step as one tick; clamp the substep count to 1..SubstepLimit.
  always_comb begin
    fixed_eff    = (fixed_q == '0) ? fts_pkg::FixedW'(1) : fixed_q;
    substeps_ext = ClW'(substeps_q);
    limit_max    = ClW'(SubstepLimit);
    if (substeps_ext == '0) begin
      limit_clamped = ClW'(1);
    end else if (substeps_ext > limit_max) begin
      limit_clamped = limit_max;
    end else begin
      limit_clamped = substeps_ext;
    end
    limit = LimW'(limit_clamped);
    prod  = ProdW'(fixed_eff) * ProdW'(limit);
  end

  assign frame_ready_o = push_ready_i;
  assign push_valid_o  = frame_valid_i;
  assign push_data_o   = {frame_delta_i, mode_q, fixed_eff, limit, prod};

endmodule

### src/fts_queue.sv
// Short FIFO between the front and back parts of the fixed timestep scheduler.
// Generic width and depth; registers only. Uses fts_pkg for the default depth.
module fts_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = fts_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q;
  logic [PtrW-1:0]  rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### src/fts_divider.sv
// Restoring divider for the fixed timestep scheduler: accumulator / substep limit,
// one quotient bit per cycle. Uses fts_pkg for parameter defaults.
module fts_divider #(
  parameter int unsigned TimeWidth    = fts_pkg::TimeWidthDef,
  parameter int unsigned SubstepLimit = fts_pkg::SubstepLimitDef,
  parameter int unsigned LimW         = $clog2(SubstepLimit + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [TimeWidth-1:0] dividend_i,
  input  logic [LimW-1:0]      divisor_i,
  output logic                 done_o,
  output logic [TimeWidth-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(TimeWidth + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CntW-1:0]      cnt_q;
  logic [LimW-1:0]      rem_q;
  logic [LimW-1:0]      rem_d;
  logic [TimeWidth-1:0] quo_q;
  logic [LimW:0]        shifted;
  logic [LimW:0]        diff;
  logic                 fits;

  // Shift in the next dividend bit and subtract the divisor if it fits.
  always_comb begin
    shifted = {rem_q, quo_q[TimeWidth-1]};
    diff    = shifted - {1'b0, divisor_i};
    fits    = (shifted >= {1'b0, divisor_i});
    rem_d   = fits ? diff[LimW-1:0] : shifted[LimW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(TimeWidth);
      rem_q  <= '0;
      quo_q  <= dividend_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[TimeWidth-2:0], fits};
      rem_q <= rem_d;
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### src/fts_back.sv
// Back part of the fixed timestep scheduler: time accumulator, step sequencer and
// output register. Takes classified frames from the queue. Uses fts_pkg; drives fts_divider through its ports.
module fts_back #(
  parameter int unsigned TimeWidth    = fts_pkg::TimeWidthDef,
  parameter int unsigned SubstepLimit = fts_pkg::SubstepLimitDef,
  parameter int unsigned LimW         = $clog2(SubstepLimit + 1),
  parameter int unsigned ProdW        = fts_pkg::FixedW + LimW,
  parameter int unsigned EntryW       = fts_pkg::DeltaW + fts_pkg::ModeW + fts_pkg::FixedW
                                        + LimW + ProdW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       pop_valid_i,
  output logic                       pop_ready_o,
  input  logic [EntryW-1:0]          pop_data_i,
  output logic                       div_start_o,
  output logic [TimeWidth-1:0]       div_dividend_o,
  output logic [LimW-1:0]            div_divisor_o,
  input  logic                       div_done_i,
  input  logic [TimeWidth-1:0]       div_quotient_i,
  output logic                       step_valid_o,
  input  logic                       step_ready_i,
  output logic [fts_pkg::OutW-1:0]   step_ticks_o,
  output logic                       has_step_o,
  output logic                       is_last_o,
  output logic [fts_pkg::OutW-1:0]   leftover_ticks_o
);

  localparam int unsigned StepW = (TimeWidth > fts_pkg::FixedW) ? TimeWidth : fts_pkg::FixedW;
  localparam int unsigned CmpW  = (TimeWidth > ProdW) ? TimeWidth : ProdW;
  localparam int unsigned SumW  = ((TimeWidth > fts_pkg::DeltaW) ? TimeWidth
                                                                 : fts_pkg::DeltaW) + 1;
  localparam int unsigned CntW  = LimW + 1;
  localparam logic [SumW-1:0] TimeMax = SumW'({TimeWidth{1'b1}});

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_DECIDE,
    ST_DIV,
    ST_CHECK,
    ST_TAKE,
    ST_FLUSH
  } state_e;

  logic [fts_pkg::DeltaW-1:0] e_delta;
  logic [fts_pkg::ModeW-1:0]  e_mode;
  logic [fts_pkg::FixedW-1:0] e_fixed;
  logic [LimW-1:0]            e_limit;
  logic [ProdW-1:0]           e_prod;

  state_e                     state_q;
  fts_pkg::mode_e             mode_q;
  logic [fts_pkg::DeltaW-1:0] delta_q;
  logic [fts_pkg::FixedW-1:0] fixed_q;
  logic [LimW-1:0]            limit_q;
  logic [ProdW-1:0]           prod_q;
  logic [TimeWidth-1:0]       acc_q;
  logic [StepW-1:0]           step_q;
  logic [CntW-1:0]            n_q;
  logic                       pend_v_q;
  logic [TimeWidth-1:0]       pend_step_q;
  logic [TimeWidth-1:0]       pend_left_q;
  logic                       div_start_q;
  logic                       out_v_q;
  logic [fts_pkg::OutW-1:0]   out_step_q;
  logic                       out_has_q;
  logic                       out_last_q;
  logic [fts_pkg::OutW-1:0]   out_left_q;

  logic [SumW-1:0]      sum;
  logic [TimeWidth-1:0] acc_sat;
  logic [StepW-1:0]     fixed_s;
  logic [StepW-1:0]     acc_s;
  logic [StepW-1:0]     min_step;
  logic                 need_widen;
  logic                 cont;
  logic [StepW-1:0]     take_s;
  logic [TimeWidth-1:0] take_t;
  logic [TimeWidth-1:0] acc_next;
  logic                 out_free;
  logic                 out_load;
  logic                 div_start_d;

  assign {e_delta, e_mode, e_fixed, e_limit, e_prod} = pop_data_i;

  always_comb begin
    sum        = SumW'(acc_q) + SumW'(delta_q);
    acc_sat    = (sum > TimeMax) ? '1 : sum[TimeWidth-1:0];
    fixed_s    = StepW'(fixed_q);
    acc_s      = StepW'(acc_q);
    min_step   = fixed_s >> 2;
    need_widen = (CmpW'(prod_q) < CmpW'(acc_q));
    case (mode_q)
      fts_pkg::MODE_FIXED: begin
        cont   = (acc_s >= fixed_s) && (n_q < CntW'(limit_q));
        take_s = fixed_s;
      end
      fts_pkg::MODE_SEMI_FIXED: begin
        cont   = (acc_s > min_step) && (n_q <= CntW'(limit_q));
        take_s = (step_q < acc_s) ? step_q : acc_s;
      end
      default: begin
        cont   = 1'b0;
        take_s = '0;
      end
    endcase
    take_t   = TimeWidth'(take_s);
    acc_next = acc_q - take_t;
    out_free = !out_v_q || step_ready_i;
    // The output register takes a new result this cycle.
    out_load = out_free && (((state_q == ST_TAKE) && pend_v_q) || (state_q == ST_FLUSH));
    div_start_d = (state_q == ST_DECIDE) && (mode_q == fts_pkg::MODE_SEMI_FIXED)
                  && need_widen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= fts_pkg::MODE_FIXED;
      delta_q     <= '0;
      fixed_q     <= '0;
      limit_q     <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      step_q      <= '0;
      n_q         <= '0;
      pend_v_q    <= 1'b0;
      pend_step_q <= '0;
      pend_left_q <= '0;
      div_start_q <= 1'b0;
      out_v_q     <= 1'b0;
      out_step_q  <= '0;
      out_has_q   <= 1'b0;
      out_last_q  <= 1'b0;
      out_left_q  <= '0;
    end else begin
      div_start_q <= div_start_d;
      if (out_v_q && step_ready_i && !out_load) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            delta_q  <= e_delta;
            mode_q   <= fts_pkg::mode_e'(e_mode);
            fixed_q  <= e_fixed;
            limit_q  <= e_limit;
            prod_q   <= e_prod;
            n_q      <= '0;
            pend_v_q <= 1'b0;
            state_q  <= ST_ADD;
          end
        end
        ST_ADD: begin
          acc_q   <= acc_sat;
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          case (mode_q)
            fts_pkg::MODE_VARIABLE: begin
              pend_v_q    <= 1'b1;
              pend_step_q <= acc_q;
              pend_left_q <= '0;
              acc_q       <= '0;
              state_q     <= ST_FLUSH;
            end
            fts_pkg::MODE_SEMI_FIXED: begin
              if (need_widen) begin
                state_q <= ST_DIV;
              end else begin
                step_q  <= fixed_s;
                state_q <= ST_CHECK;
              end
            end
            default: begin
              state_q <= ST_CHECK;
            end
          endcase
        end
        ST_DIV: begin
          if (div_done_i) begin
            step_q  <= StepW'(div_quotient_i);
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_q <= cont ? ST_TAKE : ST_FLUSH;
        end
        ST_TAKE: begin
          // A further step is due, so the held step is not the frame's last.
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              out_v_q    <= 1'b1;
              out_step_q <= fts_pkg::OutW'(pend_step_q);
              out_has_q  <= 1'b1;
              out_last_q <= 1'b0;
              out_left_q <= fts_pkg::OutW'(pend_left_q);
            end
            pend_v_q    <= 1'b1;
            pend_step_q <= take_t;
            pend_left_q <= acc_next;
            acc_q       <= acc_next;
            n_q         <= n_q + CntW'(1);
            state_q     <= ST_CHECK;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_v_q    <= 1'b1;
            out_last_q <= 1'b1;
            if (pend_v_q) begin
              out_step_q <= fts_pkg::OutW'(pend_step_q);
              out_has_q  <= 1'b1;
              out_left_q <= fts_pkg::OutW'(pend_left_q);
            end else begin
              out_step_q <= '0;
              out_has_q  <= 1'b0;
              out_left_q <= fts_pkg::OutW'(acc_q);
            end
            pend_v_q <= 1'b0;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign pop_ready_o      = (state_q == ST_IDLE);
  assign div_start_o      = div_start_q;
  assign div_dividend_o   = acc_q;
  assign div_divisor_o    = limit_q;
  assign step_valid_o     = out_v_q;
  assign step_ticks_o     = out_step_q;
  assign has_step_o       = out_has_q;
  assign is_last_o        = out_last_q;
  assign leftover_ticks_o = out_left_q;

endmodule

### src/fts_checker.sv
// Port-level checks for the fixed timestep scheduler, bound to its top level.
// Depends on fts_pkg and fixed_timestep_scheduler.
module fts_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     step_valid_o,
  input logic                     step_ready_i,
  input logic [fts_pkg::OutW-1:0] step_ticks_o,
  input logic                     has_step_o,
  input logic                     is_last_o
);

  // A stalled step holds.
  a_step_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_valid_o && !step_ready_i |=> step_valid_o && $stable(step_ticks_o)
                                      && $stable(is_last_o))
    else $error("step output changed while stalled");

  // An empty result closes its frame and carries no time.
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_valid_o && !has_step_o |-> is_last_o && (step_ticks_o == '0))
    else $error("empty result is not a zero-length last item");

  // Only real, nonzero steps can be followed by more steps of the same frame.
  a_inner_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_valid_o && !is_last_o |-> has_step_o && (step_ticks_o != '0))
    else $error("non-final result without a nonzero step");

endmodule

bind fixed_timestep_scheduler fts_checker u_fts_checker (.*);
